// File: design/nbe_pkg.sv
// Shared types, constants and exponent tables for the neighbour edge weight block.
// Used by the front end, back end and top level; depends on nothing else.
// The exponent tables are built at elaboration by constant functions.
package nbe_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int CHANNEL_BITS_DEF = 8;

    // Exponent tables
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int EXP_IDX_BITS    = $clog2(EXP_TABLE_DEPTH);
    localparam int INT_STEPS       = 32;

    // Fixed field widths
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 16;
    localparam int BETA_BITS   = 32;
    localparam int GAMMA_BITS  = 16;
    localparam int WEIGHT_BITS = 24;
    localparam int NUM_NBRS    = 4;
    localparam int FLAG_BITS   = NUM_NBRS + 2;
    localparam int OUT_W       = NUM_NBRS * WEIGHT_BITS;

    // 1/sqrt2 in Q32
    localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;

    // Register reset values
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 16'd1024;
    localparam logic [BETA_BITS-1:0]   BETA_RST   = 32'd16777216;
    localparam logic [GAMMA_BITS-1:0]  GAMMA_RST  = 16'd12800;

    // Neighbour slots, in result order
    localparam int NBR_LEFT    = 0;
    localparam int NBR_UPLEFT  = 1;
    localparam int NBR_UP      = 2;
    localparam int NBR_UPRIGHT = 3;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_BETA   = 2'd2,
        CFG_GAMMA  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0]  width;
        logic [HEIGHT_BITS-1:0] height;
        logic [BETA_BITS-1:0]   beta;
        logic [GAMMA_BITS-1:0]  gamma;
    } cfg_t;

    // Classification of one pixel, made by the front end
    typedef struct packed {
        logic                frame_end;
        logic                row_end;
        logic [NUM_NBRS-1:0] present;
    } nbr_flags_t;

    typedef enum logic {
        F_IDLE,
        F_LOOK
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIST,
        B_SCALE,
        B_INDEX,
        B_LOOK,
        B_EXP,
        B_GAIN,
        B_EMIT
    } back_state_t;

    typedef logic [31:0] frac_tab_t [EXP_TABLE_DEPTH];
    typedef logic [31:0] int_tab_t  [INT_STEPS];

    // Q48 to Q31 with rounding
    function automatic logic [63:0] q48_to_q31_pad(input logic [63:0] v);
        return (v + 64'd65536) >> 17;
    endfunction

    function automatic logic [31:0] q48_to_q31(input logic [63:0] v);
        logic [63:0] r;
        r = q48_to_q31_pad(v);
        return r[31:0];
    endfunction

    // Unsigned restoring division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-i/EXP_TABLE_DEPTH) in Q48, truncating Taylor series
    function automatic logic [63:0] frac_series(input int unsigned i);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'd1 << 48;
        pos  = term;
        neg  = '0;
        for (int n = 1; n <= 24; n++) begin
            term = udiv64(term * 64'(i), 64'(EXP_TABLE_DEPTH) * 64'(n));
            if (n[0]) neg = neg + term;
            else      pos = pos + term;
        end
        return pos - neg;
    endfunction

    // exp(-1) in Q48, same series
    function automatic logic [63:0] unit_series();
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'd1 << 48;
        pos  = term;
        neg  = '0;
        for (int n = 1; n <= 24; n++) begin
            term = udiv64(term, 64'(n));
            if (n[0]) neg = neg + term;
            else      pos = pos + term;
        end
        return pos - neg;
    endfunction

    function automatic frac_tab_t build_frac();
        frac_tab_t t;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            t[i] = q48_to_q31(frac_series(i));
        end
        return t;
    endfunction

    function automatic int_tab_t build_int();
        int_tab_t    t;
        logic [63:0] e1;
        logic [63:0] p;
        e1   = 64'(q48_to_q31(unit_series()));
        t[0] = 32'h8000_0000;
        for (int k = 1; k < INT_STEPS; k++) begin
            p    = 64'(t[k-1]) * e1 + (64'd1 << 30);
            t[k] = p[62:31];
        end
        return t;
    endfunction

    localparam frac_tab_t FRAC_TAB = build_frac();
    localparam int_tab_t  INT_TAB  = build_int();

endpackage

// File: design/nbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the line store; no dependencies.
module nbe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/nbe_front.sv
// Front end: accepts pixels, tracks column/row, reads the line store and
// classifies each pixel's neighbours. Depends on nbe_pkg and nbe_ram.
module nbe_front #(
    parameter int MAX_WIDTH    = nbe_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = nbe_pkg::CHANNEL_BITS_DEF,
    localparam int PW      = 3 * CHANNEL_BITS,
    localparam int ENTRY_W = (nbe_pkg::NUM_NBRS + 1) * PW + nbe_pkg::FLAG_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nbe_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PW-1:0]      in_pixel,
    input  logic               q_room,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = (XW + 1 > nbe_pkg::WIDTH_BITS) ? XW + 1 : nbe_pkg::WIDTH_BITS;
    localparam int HB = nbe_pkg::HEIGHT_BITS;

    nbe_pkg::front_state_t state_reg, state_next;
    logic [XW-1:0] col_reg;
    logic [HB-1:0] row_reg;
    logic [PW-1:0] pix_reg;
    logic [PW-1:0] prior_reg;
    logic [PW-1:0] upleft_reg;

    logic [PW-1:0] up_pix, ur_pix;
    logic [WW-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic          accept, look;
    logic          last_col, last_row;
    logic [HB:0]   row_inc;
    nbe_pkg::nbr_flags_t flags;

    // Effective geometry
    always_comb
    begin
        if (cfg.width == '0)
            w_eff = WW'(1);
        else if (WW'(cfg.width) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg.width);
        h_eff = (cfg.height == '0) ? HB'(1) : cfg.height;
    end

    assign accept   = in_valid && in_ready;
    assign look     = (state_reg == nbe_pkg::F_LOOK);
    assign in_ready = (state_reg == nbe_pkg::F_IDLE) && q_room;

    assign last_col = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign row_inc  = {1'b0, row_reg} + (HB+1)'(1);
    assign last_row = row_inc >= {1'b0, h_eff};

    // Line store, duplicated so up and up-right read in the same cycle
    nbe_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_ram_up (
        .clk   (clk),
        .we    (look),
        .waddr (col_reg),
        .wdata (pix_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up_pix)
    );

    nbe_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_ram_ur (
        .clk   (clk),
        .we    (look),
        .waddr (col_reg),
        .wdata (pix_reg),
        .re    (accept),
        .raddr (col_reg + XW'(1)),
        .rdata (ur_pix)
    );

    // Neighbour classification
    always_comb
    begin
        flags.present[nbe_pkg::NBR_LEFT]    = (col_reg != '0);
        flags.present[nbe_pkg::NBR_UPLEFT]  = (col_reg != '0) && (row_reg != '0);
        flags.present[nbe_pkg::NBR_UP]      = (row_reg != '0);
        flags.present[nbe_pkg::NBR_UPRIGHT] = (row_reg != '0) && !last_col;
        flags.row_end   = last_col;
        flags.frame_end = last_col && last_row;
    end

    assign q_push = look;
    assign q_data = {flags, ur_pix, up_pix, upleft_reg, prior_reg, pix_reg};

    // State machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nbe_pkg::F_IDLE:
            begin
                if (accept)
                    state_next = nbe_pkg::F_LOOK;
            end
            nbe_pkg::F_LOOK:
            begin
                state_next = nbe_pkg::F_IDLE;
            end
            default:
            begin
                state_next = nbe_pkg::F_IDLE;
            end
        endcase
    end

    // Control and neighbour history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nbe_pkg::F_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            prior_reg  <= '0;
            upleft_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (look)
            begin
                prior_reg  <= pix_reg;
                upleft_reg <= up_pix;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_inc[HB-1:0];
                end
                else
                begin
                    col_reg <= col_reg + XW'(1);
                end
            end
        end
    end

    // Pixel beat holding
    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= in_pixel;
    end

endmodule

// File: design/nbe_queue.sv
// Two-entry queue between front and back end.
// Depends on nothing else.
module nbe_queue #(
    parameter int WIDTH = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] data_in,
    output logic             room,
    input  logic             pop,
    output logic             nonempty,
    output logic [WIDTH-1:0] data_out
);

    logic [WIDTH-1:0] slot [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign room     = (count_reg != 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign data_out = slot[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot[wr_ptr_reg] <= data_in;
    end

endmodule

// File: design/nbe_back.sv
// Back end: computes the left, up-left, up and up-right edge weights of a pixel in turn
// through a shared exponent unit and holds the result beat. Depends on nbe_pkg.
module nbe_back #(
    parameter int CHANNEL_BITS = nbe_pkg::CHANNEL_BITS_DEF,
    localparam int PW      = 3 * CHANNEL_BITS,
    localparam int ENTRY_W = (nbe_pkg::NUM_NBRS + 1) * PW + nbe_pkg::FLAG_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  nbe_pkg::cfg_t             cfg,
    input  logic                      q_valid,
    output logic                      q_pop,
    input  logic [ENTRY_W-1:0]        q_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [nbe_pkg::OUT_W-1:0] out_weights,
    output logic                      out_last,
    output logic                      out_flag
);

    localparam int C     = CHANNEL_BITS;
    localparam int DW    = 2 * C + 2;
    localparam int XBITS = nbe_pkg::BETA_BITS + DW;
    localparam int IB    = nbe_pkg::EXP_IDX_BITS;
    localparam int SB    = 25 + IB;
    localparam int WB    = nbe_pkg::WEIGHT_BITS;

    nbe_pkg::back_state_t state_reg, state_next;
    logic [1:0]           k_reg;
    logic [ENTRY_W-1:0]   cur_reg;
    logic [DW-1:0]        d_reg;
    logic [XBITS-1:0]     x_reg;
    logic [31:0]          g_reg;
    logic [IB-1:0]        idx_reg;
    logic [4:0]           ip_reg;
    logic                 zero_reg;
    logic [31:0]          frac_reg, int_reg, e_reg;
    logic [WB-1:0]        wt_reg [nbe_pkg::NUM_NBRS];
    logic                 out_valid_reg;
    logic [nbe_pkg::OUT_W-1:0] out_data_reg;
    logic                 out_last_reg, out_flag_reg;

    nbe_pkg::nbr_flags_t  flags;
    logic [PW-1:0]        pix;
    logic [PW-1:0]        nbr [nbe_pkg::NUM_NBRS];
    logic [DW-1:0]        d_sum;
    logic [C-1:0]         ca, cb, diff;
    logic [47:0]          g_diag;
    logic [SB-1:0]        scaled;
    logic [IB:0]          idx_full;
    logic                 wrap;
    logic [5:0]           ip6;
    logic                 big;
    logic [63:0]          e_prod, w_prod;
    logic [25:0]          w_q;
    logic [WB-1:0]        w_sat;
    logic                 emit;

    // Unpack the current item
    always_comb
    begin
        flags = cur_reg[ENTRY_W-1 -: nbe_pkg::FLAG_BITS];
        pix   = cur_reg[PW-1:0];
        for (int n = 0; n < nbe_pkg::NUM_NBRS; n++)
        begin
            nbr[n] = cur_reg[PW*(n+1) +: PW];
        end
    end

    // Squared colour distance to the selected neighbour
    always_comb
    begin
        d_sum = '0;
        for (int c = 0; c < 3; c++)
        begin
            ca    = pix[c*C +: C];
            cb    = nbr[k_reg][c*C +: C];
            diff  = (ca > cb) ? ca - cb : cb - ca;
            d_sum = d_sum + DW'(diff * diff);
        end
    end

    // Diagonal gain, gamma/sqrt2 in Q24
    assign g_diag = (48'(cfg.gamma) * 48'(nbe_pkg::INV_SQRT2_Q32) + 48'h8000) >> 16;

    // Split the exponent into table indexes
    always_comb
    begin
        scaled   = SB'(x_reg[23:0]) * SB'(nbe_pkg::EXP_TABLE_DEPTH) + SB'(1 << 23);
        idx_full = scaled[SB-1:24];
        wrap     = (idx_full == (IB+1)'(nbe_pkg::EXP_TABLE_DEPTH));
        ip6      = {1'b0, x_reg[28:24]} + 6'(wrap);
        big      = |x_reg[XBITS-1:29];
    end

    // Exponent product and gain
    assign e_prod = 64'(int_reg) * 64'(frac_reg);
    assign w_prod = 64'(g_reg) * 64'(e_reg) + (64'd1 << 37);
    assign w_q    = w_prod[63:38];
    assign w_sat  = (w_q[25:24] != 2'b00) ? {WB{1'b1}} : w_q[WB-1:0];

    assign q_pop = (state_reg == nbe_pkg::B_IDLE) && q_valid;
    assign emit  = (state_reg == nbe_pkg::B_EMIT) && (!out_valid_reg || out_ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nbe_pkg::B_IDLE:  if (q_valid) state_next = nbe_pkg::B_DIST;
            nbe_pkg::B_DIST:  state_next = nbe_pkg::B_SCALE;
            nbe_pkg::B_SCALE: state_next = nbe_pkg::B_INDEX;
            nbe_pkg::B_INDEX: state_next = nbe_pkg::B_LOOK;
            nbe_pkg::B_LOOK:  state_next = nbe_pkg::B_EXP;
            nbe_pkg::B_EXP:   state_next = nbe_pkg::B_GAIN;
            nbe_pkg::B_GAIN:
            begin
                state_next = (k_reg == 2'd3) ? nbe_pkg::B_EMIT : nbe_pkg::B_DIST;
            end
            nbe_pkg::B_EMIT:  if (emit) state_next = nbe_pkg::B_IDLE;
            default:          state_next = nbe_pkg::B_IDLE;
        endcase
    end

    // Control state and result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nbe_pkg::B_IDLE;
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
                k_reg <= 2'd0;
            else if (state_reg == nbe_pkg::B_GAIN)
                k_reg <= k_reg + 2'd1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        case (state_reg)
            nbe_pkg::B_IDLE:
            begin
                if (q_valid)
                    cur_reg <= q_data;
            end
            nbe_pkg::B_DIST:
            begin
                d_reg <= d_sum;
            end
            nbe_pkg::B_SCALE:
            begin
                x_reg <= XBITS'(cfg.beta) * XBITS'(d_reg);
                g_reg <= k_reg[0] ? g_diag[31:0] : {cfg.gamma, 16'h0000};
            end
            nbe_pkg::B_INDEX:
            begin
                idx_reg  <= wrap ? '0 : idx_full[IB-1:0];
                ip_reg   <= ip6[4:0];
                zero_reg <= big || ip6[5] || !flags.present[k_reg];
            end
            nbe_pkg::B_LOOK:
            begin
                frac_reg <= nbe_pkg::FRAC_TAB[idx_reg];
                int_reg  <= nbe_pkg::INT_TAB[ip_reg];
            end
            nbe_pkg::B_EXP:
            begin
                e_reg <= e_prod[63:32];
            end
            nbe_pkg::B_GAIN:
            begin
                wt_reg[k_reg] <= zero_reg ? '0 : w_sat;
            end
            default:
            begin
                if (emit)
                begin
                    out_data_reg <= {wt_reg[3], wt_reg[2], wt_reg[1], wt_reg[0]};
                    out_last_reg <= flags.row_end;
                    out_flag_reg <= flags.frame_end;
                end
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_weights = out_data_reg;
    assign out_last    = out_last_reg;
    assign out_flag    = out_flag_reg;

endmodule

// File: design/neighbour_edge_weights.sv
// 8-neighbour edge weights on a raster pixel stream. The shared exponent unit sets
// the pixel rate: the back end takes the four weights of a pixel in turn, each
// through its DIST, SCALE, INDEX, LOOK, EXP and GAIN states, and takes no new pixel
// until the result beat is emitted; the front end runs ahead through the queue.
// Reset (rst_n, async, low) clears counters, history, queue and registers to
// their defaults; the line store is not cleared and needs no clearing pass.
module neighbour_edge_weights #(
    parameter int MAX_WIDTH    = nbe_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = nbe_pkg::CHANNEL_BITS_DEF,
    localparam int PW    = 3 * CHANNEL_BITS,
    localparam int IN_W  = ((PW + 7) / 8) * 8,
    localparam int OUT_W = nbe_pkg::OUT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    // Pixel beats
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // channel_a, channel_b, channel_c
    // Weight beats
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // left, upleft, up, upright weights
    output logic             m_tlast,   // row_end
    output logic             m_tuser,   // frame_end
    // Register writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    localparam int ENTRY_W = (nbe_pkg::NUM_NBRS + 1) * PW + nbe_pkg::FLAG_BITS;

    nbe_pkg::cfg_t      cfg_reg;
    logic               q_room, q_push, q_nonempty, q_pop;
    logic [ENTRY_W-1:0] q_in, q_out;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= nbe_pkg::WIDTH_RST;
            cfg_reg.height <= nbe_pkg::HEIGHT_RST;
            cfg_reg.beta   <= nbe_pkg::BETA_RST;
            cfg_reg.gamma  <= nbe_pkg::GAMMA_RST;
        end
        else if (cfg_valid)
        begin
            unique case (nbe_pkg::cfg_index_t'(cfg_index))
                nbe_pkg::CFG_WIDTH:  cfg_reg.width  <= cfg_data[nbe_pkg::WIDTH_BITS-1:0];
                nbe_pkg::CFG_HEIGHT: cfg_reg.height <= cfg_data[nbe_pkg::HEIGHT_BITS-1:0];
                nbe_pkg::CFG_BETA:   cfg_reg.beta   <= cfg_data;
                nbe_pkg::CFG_GAMMA:  cfg_reg.gamma  <= cfg_data[nbe_pkg::GAMMA_BITS-1:0];
                default:             cfg_reg        <= cfg_reg;
            endcase
        end
    end

    nbe_front #(.MAX_WIDTH(MAX_WIDTH), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_pixel (s_tdata[PW-1:0]),
        .q_room   (q_room),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    nbe_queue #(.WIDTH(ENTRY_W)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_in),
        .room     (q_room),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .data_out (q_out)
    );

    nbe_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_nonempty),
        .q_pop       (q_pop),
        .q_data      (q_out),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_weights (m_tdata),
        .out_last    (m_tlast),
        .out_flag    (m_tuser)
    );

endmodule

// File: design/nbe_checker.sv
// Port-level checks for the neighbour edge weight block, bound to the top level.
// Depends on the top level's ports only.
module nbe_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    logic [3:0] pending_reg;
    logic       row_start_reg, frame_start_reg;
    logic       in_beat, out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // Beats in flight and position of the next result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= '0;
            row_start_reg   <= 1'b1;
            frame_start_reg <= 1'b1;
        end
        else
        begin
            if (in_beat && !out_beat)
                pending_reg <= pending_reg + 4'd1;
            else if (out_beat && !in_beat)
                pending_reg <= pending_reg - 4'd1;
            if (out_beat)
            begin
                row_start_reg   <= m_tlast;
                frame_start_reg <= m_tuser;
            end
        end
    end

    // A stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Frame end only at a row end
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tuser || m_tlast))
        else $error("frame end without row end");

    // No result without a pixel taken
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> pending_reg != 4'd0)
        else $error("result beat with no pixel outstanding");

    // First column has no left or up-left neighbour
    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && row_start_reg |-> m_tdata[23:0] == 24'd0 && m_tdata[47:24] == 24'd0)
        else $error("left weight nonzero in first column");

    // First row has no up or up-right neighbour
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && frame_start_reg |-> m_tdata[71:48] == 24'd0 && m_tdata[95:72] == 24'd0)
        else $error("up weight nonzero in first row");

endmodule

bind neighbour_edge_weights nbe_port_checks u_nbe_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: tb/sv/nbe_checker.sv
`timescale 1ns / 100ps
// Checker for neighbour_edge_weights: watches the pixel, weight and register channels,
// predicts every weight beat and compares it field by field. Depends on nbe_pkg.
module nbe_checker
    import nbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [23:0] left;
        logic [23:0] upleft;
        logic [23:0] up;
        logic [23:0] upright;
        logic        row_end;
        logic        frame_end;
    } weight_beat_t;

    // Exponent tables: fraction steps and integer steps, both Q31
    longint unsigned decay_frac[EXP_TABLE_DEPTH];
    longint unsigned decay_unit[INT_STEPS];

    // Register copies
    logic [10:0] img_width;
    logic [15:0] img_height;
    logic [31:0] beta_q24;
    logic [15:0] gamma_q8;

    // Pixel history
    logic [23:0] line_buf [MAX_WIDTH_DEF];
    logic [23:0] last_pix;
    logic [23:0] diag_pix;
    int unsigned col_cnt;
    logic [15:0] row_cnt;

    weight_beat_t weights_due[$];

    // exp(-num/den) in Q48, truncating series
    function automatic longint unsigned taylor_q48(longint unsigned num, longint unsigned den);
        longint unsigned term;
        longint unsigned plus;
        longint unsigned minus;
        term  = 64'd1 << 48;
        plus  = term;
        minus = 0;
        for (int n = 1; n <= 24; n++)
        begin
            term = term * num / (den * n);
            if (n % 2 == 1) minus += term;
            else            plus  += term;
        end
        return plus - minus;
    endfunction

    function automatic longint unsigned round_q31(longint unsigned v);
        return (v + (64'd1 << 16)) >> 17;
    endfunction

    function automatic longint unsigned colour_dist(logic [23:0] p, logic [23:0] q);
        longint unsigned sum;
        longint unsigned a;
        longint unsigned b;
        sum = 0;
        for (int c = 0; c < 3; c++)
        begin
            a = p[c*8 +: 8];
            b = q[c*8 +: 8];
            sum += (a > b) ? (a - b) * (a - b) : (b - a) * (b - a);
        end
        return sum;
    endfunction

    // exp(-beta * d) in Q30
    function automatic longint unsigned decay_q30(longint unsigned d);
        longint unsigned beta;
        longint unsigned x;
        longint unsigned ip;
        longint unsigned idx;
        beta = beta_q24;
        if (d != 0 && beta > (64'd32 << 24) / d) return 0;
        x   = beta * d;
        ip  = x >> 24;
        idx = ((x & 64'hFF_FFFF) * EXP_TABLE_DEPTH + (64'd1 << 23)) >> 24;
        if (idx >= EXP_TABLE_DEPTH)
        begin
            idx = 0;
            ip++;
        end
        if (ip >= INT_STEPS) return 0;
        return (decay_unit[ip] * decay_frac[idx]) >> 32;
    endfunction

    function automatic logic [23:0] edge_weight(longint unsigned gain, logic [23:0] p,
                                                logic [23:0] q);
        longint unsigned w;
        w = (gain * decay_q30(colour_dist(p, q)) + (64'd1 << 37)) >> 38;
        return (w > 64'hFF_FFFF) ? 24'hFF_FFFF : w[23:0];
    endfunction

    // Work out the weight beat of one pixel and advance the raster position
    function automatic weight_beat_t predict_weights(logic [23:0] pix);
        weight_beat_t    r;
        int unsigned     w;
        int unsigned     h;
        int unsigned     xi;
        logic [23:0]     up_pix;
        logic [23:0]     ur_pix;
        longint unsigned g_str;
        longint unsigned g_diag;
        w  = (img_width == 0) ? 1 : ((img_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : img_width);
        h  = (img_height == 0) ? 1 : img_height;
        xi = (col_cnt < MAX_WIDTH_DEF) ? col_cnt : MAX_WIDTH_DEF - 1;
        g_str  = longint'(gamma_q8) << 16;
        g_diag = (longint'(gamma_q8) * longint'(INV_SQRT2_Q32) + (64'd1 << 15)) >> 16;
        up_pix = line_buf[xi];
        ur_pix = (col_cnt + 1 < w) ? line_buf[col_cnt + 1] : '0;

        r.left    = (col_cnt > 0) ? edge_weight(g_str, pix, last_pix) : '0;
        r.upleft  = (col_cnt > 0 && row_cnt > 0) ? edge_weight(g_diag, pix, diag_pix) : '0;
        r.up      = (row_cnt > 0) ? edge_weight(g_str, pix, up_pix) : '0;
        r.upright = (row_cnt > 0 && col_cnt + 1 < w) ? edge_weight(g_diag, pix, ur_pix) : '0;

        diag_pix     = up_pix;
        line_buf[xi] = pix;
        last_pix     = pix;

        r.row_end   = (col_cnt + 1 >= w);
        r.frame_end = r.row_end && (row_cnt + 1 >= h);
        if (r.row_end)
        begin
            col_cnt = 0;
            row_cnt = r.frame_end ? 16'd0 : row_cnt + 16'd1;
        end
        else
        begin
            col_cnt = col_cnt + 1;
        end
        return r;
    endfunction

    initial
    begin
        longint unsigned e1;
        errors  = 0;
        pending = 0;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
            decay_frac[i] = round_q31(taylor_q48(i, EXP_TABLE_DEPTH));
        e1 = round_q31(taylor_q48(1, 1));
        decay_unit[0] = 64'd1 << 31;
        for (int k = 1; k < INT_STEPS; k++)
            decay_unit[k] = (decay_unit[k-1] * e1 + (64'd1 << 30)) >> 31;
    end

    always @(posedge clk or negedge rst_n)
    begin
        weight_beat_t want;
        if (!rst_n)
        begin
            img_width  = 11'd1024;
            img_height = 16'd1024;
            beta_q24   = 32'd16777216;
            gamma_q8   = 16'd12800;
            last_pix   = '0;
            diag_pix   = '0;
            col_cnt    = 0;
            row_cnt    = '0;
            weights_due.delete();
            pending    = 0;
        end
        else
        begin
            // register write beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_WIDTH:  img_width  = cfg_data[10:0];
                    CFG_HEIGHT: img_height = cfg_data[15:0];
                    CFG_BETA:   beta_q24   = cfg_data;
                    CFG_GAMMA:  gamma_q8   = cfg_data[15:0];
                endcase
            end
            // pixel beat
            if (s_tvalid && s_tready)
                weights_due.push_back(predict_weights(s_tdata));
            // weight beat
            if (m_tvalid && m_tready)
            begin
                if (weights_due.size() == 0)
                begin
                    $error("weight beat with nothing expected");
                    errors++;
                end
                else
                begin
                    want = weights_due.pop_front();
                    if (m_tdata[23:0] !== want.left)
                    begin
                        $error("left_weight expected %0d got %0d", want.left, m_tdata[23:0]);
                        errors++;
                    end
                    if (m_tdata[47:24] !== want.upleft)
                    begin
                        $error("upleft_weight expected %0d got %0d", want.upleft,
                               m_tdata[47:24]);
                        errors++;
                    end
                    if (m_tdata[71:48] !== want.up)
                    begin
                        $error("up_weight expected %0d got %0d", want.up, m_tdata[71:48]);
                        errors++;
                    end
                    if (m_tdata[95:72] !== want.upright)
                    begin
                        $error("upright_weight expected %0d got %0d", want.upright,
                               m_tdata[95:72]);
                        errors++;
                    end
                    if (m_tlast !== want.row_end)
                    begin
                        $error("row_end expected %0d got %0d", want.row_end, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== want.frame_end)
                    begin
                        $error("frame_end expected %0d got %0d", want.frame_end, m_tuser);
                        errors++;
                    end
                end
            end
            pending = weights_due.size();
        end
    end

endmodule

// File: tb/sv/tb_neighbour_edge_weights.sv
`timescale 1ns / 100ps
// Top of the neighbour_edge_weights testbench: clock, reset, pixel and register
// stimulus, weight sink and verdict. Depends on nbe_pkg, the block and nbe_checker.
module tb_neighbour_edge_weights;
    import nbe_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;

    // Stimulus side view of the raster position, to stop phases at frame end
    int unsigned tx_width;
    int unsigned tx_height;
    int unsigned tx_col;
    int unsigned tx_row;
    logic [23:0] prev_pix;
    bit          tx_fast;
    bit          rx_fast;
    int          rx_beats;
    int          pix_sent;

    neighbour_edge_weights DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nbe_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Watchdog: cycles with no beat on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Weight sink with random stalls and one long hold-off
    initial
    begin
        int gap;
        m_tready = 1'b0;
        rx_beats = 0;
        @(posedge rst_n);
        forever
        begin
            if (rx_beats == 120)
                gap = 700;
            else
                gap = rx_fast ? 0 : $urandom_range(0, 19);
            repeat (gap)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            rx_beats++;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  tx_width  = value[10:0];
            CFG_HEIGHT: tx_height = value[15:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(logic [23:0] pix);
        int gap;
        int unsigned w;
        int unsigned h;
        gap = tx_fast ? 0 : $urandom_range(0, 19);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge clk); while (!s_tready);
        prev_pix = pix;
        pix_sent++;
        // follow the raster position
        w = (tx_width == 0) ? 1 : ((tx_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : tx_width);
        h = (tx_height == 0) ? 1 : tx_height;
        if (tx_col + 1 >= w)
        begin
            tx_col = 0;
            tx_row = (tx_row + 1 >= h) ? 0 : tx_row + 1;
        end
        else
        begin
            tx_col++;
        end
    endtask

    // Random pixel, often close to the previous one so weights are not all zero
    function automatic logic [23:0] next_pixel();
        logic [23:0] p;
        int          pick;
        pick = $urandom_range(0, 9);
        p    = $urandom;
        if (pick < 5)
        begin
            for (int c = 0; c < 3; c++)
                p[c*8 +: 8] = prev_pix[c*8 +: 8] + 8'($urandom_range(0, 6)) - 8'd3;
        end
        else if (pick < 6)
        begin
            p = prev_pix;
        end
        return p;
    endfunction

    task automatic send_frames(int count);
        repeat (count)
        begin
            do send_pixel(next_pixel()); while (!(tx_col == 0 && tx_row == 0));
        end
    endtask

    // Hold off until the block has returned everything, then write a geometry, beta and gamma
    task automatic new_phase(logic [31:0] w, logic [31:0] h, logic [31:0] beta,
                             logic [31:0] gamma);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_BETA, beta);
        write_reg(CFG_GAMMA, gamma);
        tx_fast = ($urandom_range(0, 3) == 0);
        rx_fast = ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        logic [23:0] corner_pix [8];
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data  = '0;
        rst_n     = 1'b0;
        tx_width  = 1024;
        tx_height = 1024;
        tx_col    = 0;
        tx_row    = 0;
        prev_pix  = '0;
        tx_fast   = 1'b0;
        rx_fast   = 1'b0;
        pix_sent  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: channel extremes on reset settings, equal and opposite pixels
        corner_pix = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
                       24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h010101};
        foreach (corner_pix[i])
            send_pixel(corner_pix[i]);
        repeat (12) send_pixel(next_pixel());

        // Geometry shrunk mid-row: the row ends at once and a new row starts
        new_phase(4, 3, 32'h0000_0800, 16'd12800);
        send_frames(2);
        // zero contrast: every present neighbour's weight equals its gain; largest gain
        new_phase(1, 5, 32'd0, 16'hFFFF);
        send_frames(2);
        // largest contrast, zero gain
        new_phase(3, 2, 32'hFFFF_FFFF, 16'd0);
        send_frames(1);
        // width above the line store acts as the widest row, useful contrast
        new_phase(2047, 1, 32'h0000_1000, 16'hFFFF);
        send_frames(1);
        // width and height of zero act as one
        new_phase(0, 0, 32'h0001_0000, 16'h1234);
        send_frames(3);
        // small frame on smallest width with an up-right neighbour
        new_phase(2, 4, 32'h0000_0400, 16'h8000);
        send_frames(1);

        // Random geometries and gains
        while (pix_sent < 1640)
        begin
            new_phase($urandom_range(1, 40), $urandom_range(1, 8),
                      $urandom >> $urandom_range(0, 31), $urandom_range(0, 65535));
            send_frames($urandom_range(1, 2));
        end

        // Tallest frame, only partly sent
        new_phase(5, 65535, 32'h0000_0900, 16'd12800);
        repeat (60) send_pixel(next_pixel());

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
